/* rtl/swnl_pkg.sv */
// Package for the sorted weighted neighbor list.
// Holds the input and result word types, action and status codes, and the cell control type.
// Used by every module of the block; depends on nothing.
package swnl_pkg;

  // Action codes carried in the input word.
  localparam logic [2:0] ACT_ADD    = 3'd0;
  localparam logic [2:0] ACT_ERASE  = 3'd1;
  localparam logic [2:0] ACT_QUERY  = 3'd2;
  localparam logic [2:0] ACT_BEST_N = 3'd3;
  localparam logic [2:0] ACT_THRESH = 3'd4;

  // Status codes carried in the result word.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NONE      = 2'd3;

  // Most results that a single list read may emit.
  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] neighbor_id;
    logic [15:0] weight_value;
    logic [5:0]  how_many;
  } in_word_t;

  typedef struct packed {
    logic [15:0] out_id;
    logic [15:0] out_weight;
    logic [5:0]  live_count;
    logic [1:0]  status;
    logic        last_of_run;
  } out_word_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_REMOVE,
    CELL_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     weight_only;
  } cell_ctrl_t;

endpackage

/* rtl/swnl_cell.sv */
// One cell of the sorted neighbor list: holds a single (weight, id) entry.
// Compares its entry with the broadcast key and shifts toward either neighbor.
// Depends on swnl_pkg.
module swnl_cell #(
  parameter int WW = 16,
  parameter int IW = 16
) (
  input  logic                 clk,
  input  swnl_pkg::cell_ctrl_t ctrl,
  input  logic [WW-1:0]        key_weight,
  input  logic [IW-1:0]        key_id,
  input  logic                 live,
  input  logic                 at_or_after_pos,
  input  logic                 left_lt,
  input  logic [WW-1:0]        left_weight,
  input  logic [IW-1:0]        left_id,
  input  logic [WW-1:0]        right_weight,
  input  logic [IW-1:0]        right_id,
  output logic [WW-1:0]        weight,
  output logic [IW-1:0]        id,
  output logic                 lt,
  output logic                 hit
);
  import swnl_pkg::*;

  logic [WW-1:0] weight_r, weight_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic          w_less, w_equal, id_less;

  assign w_less  = weight_r < key_weight;
  assign w_equal = weight_r == key_weight;
  assign id_less = id_r < key_id;

  // The entry sorts ahead of the key; only live entries take part.
  assign lt  = live && (ctrl.weight_only ? w_less : (w_less || (w_equal && id_less)));
  assign hit = live && (id_r == key_id);

  always_comb begin
    weight_nxt = weight_r;
    id_nxt     = id_r;
    unique case (ctrl.op)
      CELL_REMOVE: begin
        if (at_or_after_pos) begin
          weight_nxt = right_weight;
          id_nxt     = right_id;
        end
      end
      CELL_INSERT: begin
        // Entries ahead of the key stay; the first one not ahead takes the key,
        // and every later cell takes its left neighbor.
        if (!lt) begin
          if (left_lt) begin
            weight_nxt = key_weight;
            id_nxt     = key_id;
          end else begin
            weight_nxt = left_weight;
            id_nxt     = left_id;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    weight_r <= weight_nxt;
    id_r     <= id_nxt;
  end

  assign weight = weight_r;
  assign id     = id_r;

endmodule

/* rtl/sorted_weighted_neighbor_list.sv */
// Sorted weighted neighbor list: top level with the sequencer and the row of cells.
// The list is kept in ascending (weight, id) order in a chain of swnl_cell instances.
// Depends on swnl_pkg and swnl_cell.
//
// Usage: an input word arrives on in_valid/in_ready/in_word and names an action:
// add or update, erase, weight query, best-N or threshold read. Each word gives
// one or more result words on out_valid/out_ready/out_word; last_of_run marks the
// final result word of an input word. Both channels complete a transfer when
// valid and ready are high at a rising clock edge.
// A word is accepted in the idle state; an add then passes through lookup and
// removal, then the sorted insert; erase, query, empty reads and an add that a
// full list drops finish in lookup, and a read goes from lookup to a stream state
// that emits one entry a cycle while the receiver keeps up. This sequence is set
// by the single broadcast bus that all cells share and by the one read port that
// selects an entry for output. Only one word is in work at a time.
// A result register parts the two sides: the next input word is accepted while a
// finished result still waits there, and the sequencer stalls whenever it has a
// result to place and the receiver has not taken the previous one.
// Reset (rst_n low at a clock edge) empties the list and drops any result in
// flight; the entry contents are left as they are and are never read until written.
module sorted_weighted_neighbor_list #(
  parameter int CAPACITY    = 32,
  parameter int WEIGHT_BITS = 16,
  parameter int ID_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  swnl_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output swnl_pkg::out_word_t out_word
);
  import swnl_pkg::*;

  // Stored widths: the ports carry 16 bits, so wider settings keep 16.
  localparam int WW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
  localparam int IW = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = $clog2(CAPACITY);
  localparam int NW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {
    IDLE,
    FIND,
    INSERT,
    STREAM
  } state_t;

  state_t        state_r;
  logic [2:0]    req_action_r;
  logic [WW-1:0] req_weight_r;
  logic [IW-1:0] req_id_r;
  logic [5:0]    req_n_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [XW-1:0] ptr_r;
  logic          out_valid_r;
  out_word_t     out_word_r;

  // Cell row signals.
  cell_ctrl_t    ctrl;
  logic [WW-1:0] cell_w   [CAPACITY];
  logic [IW-1:0] cell_id  [CAPACITY];
  logic          cell_lt  [CAPACITY];
  logic          cell_hit [CAPACITY];
  logic          cell_left_lt [CAPACITY];

  // Reductions across the row.
  logic          found;
  logic [XW-1:0] hit_pos;
  logic [WW-1:0] hit_weight;
  logic          any_bound;
  logic [CW-1:0] bound_pos;
  logic [WW-1:0] rd_weight;
  logic [IW-1:0] rd_id;

  // Read window.
  logic [CW-1:0] take_n, first_best, first_thr, first_raw, span, first;
  logic          out_free, step, full, stream_last;

  assign out_free = !out_valid_r || out_ready;
  assign step     = out_free;
  assign full     = count_r == CW'(CAPACITY);
  assign in_ready = state_r == IDLE;

  // Cell control: removal happens during lookup, insertion in its own cycle.
  always_comb begin
    ctrl.op          = CELL_HOLD;
    ctrl.weight_only = state_r == FIND;
    if (step && state_r == FIND && found &&
        (req_action_r == ACT_ADD || req_action_r == ACT_ERASE)) begin
      ctrl.op = CELL_REMOVE;
    end else if (step && state_r == INSERT) begin
      ctrl.op = CELL_INSERT;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WW-1:0] left_w, right_w;
    logic [IW-1:0] left_i, right_i;
    if (i == 0) begin : g_first
      assign cell_left_lt[i] = 1'b1;
      assign left_w = cell_w[i];
      assign left_i = cell_id[i];
    end else begin : g_mid
      assign cell_left_lt[i] = cell_lt[i-1];
      assign left_w = cell_w[i-1];
      assign left_i = cell_id[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_w[i];
      assign right_i = cell_id[i];
    end else begin : g_inner
      assign right_w = cell_w[i+1];
      assign right_i = cell_id[i+1];
    end
    swnl_cell #(
      .WW(WW),
      .IW(IW)
    ) u_cell (
      .clk            (clk),
      .ctrl           (ctrl),
      .key_weight     (req_weight_r),
      .key_id         (req_id_r),
      .live           (CW'(i) < count_r),
      .at_or_after_pos(XW'(i) >= hit_pos),
      .left_lt        (cell_left_lt[i]),
      .left_weight    (left_w),
      .left_id        (left_i),
      .right_weight   (right_w),
      .right_id       (right_i),
      .weight         (cell_w[i]),
      .id             (cell_id[i]),
      .lt             (cell_lt[i]),
      .hit            (cell_hit[i])
    );
  end

  // Ids are unique in the list, so at most one cell hits; the same holds for
  // the single boundary where the row stops sorting below the threshold.
  always_comb begin
    found      = 1'b0;
    hit_pos    = '0;
    hit_weight = '0;
    any_bound  = 1'b0;
    bound_pos  = '0;
    rd_weight  = '0;
    rd_id      = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i]) begin
        found      = 1'b1;
        hit_pos    = hit_pos | XW'(i);
        hit_weight = hit_weight | cell_w[i];
      end
      if (!cell_lt[i] && cell_left_lt[i]) begin
        any_bound = 1'b1;
        bound_pos = bound_pos | CW'(i);
      end
      if (ptr_r == XW'(i)) begin
        rd_weight = rd_weight | cell_w[i];
        rd_id     = rd_id | cell_id[i];
      end
    end
  end

  // First entry of a read, limited to the heaviest MAX_RESULTS entries.
  always_comb begin
    take_n     = (NW'(req_n_r) > NW'(count_r)) ? count_r : CW'(req_n_r);
    first_best = count_r - take_n;
    first_thr  = any_bound ? bound_pos : count_r;
    first_raw  = (req_action_r == ACT_BEST_N) ? first_best : first_thr;
    span       = count_r - first_raw;
    first      = (int'(span) > MAX_RESULTS) ? count_r - CW'(MAX_RESULTS) : first_raw;
  end

  assign stream_last = (CW'(ptr_r) + CW'(1)) == count_r;

  always_comb begin
    count_nxt = count_r;
    if (ctrl.op == CELL_REMOVE) begin
      count_nxt = count_r - CW'(1);
    end else if (ctrl.op == CELL_INSERT) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        IDLE: begin
          if (in_valid) begin
            req_action_r <= in_word.action;
            req_id_r     <= in_word.neighbor_id[IW-1:0];
            req_weight_r <= in_word.weight_value[WW-1:0];
            req_n_r      <= in_word.how_many;
            state_r      <= FIND;
          end
        end
        FIND: begin
          if (step) begin
            out_word_r.out_id      <= 16'(req_id_r);
            out_word_r.out_weight  <= '0;
            out_word_r.live_count  <= 6'(count_nxt);
            out_word_r.last_of_run <= 1'b1;
            state_r                <= IDLE;
            unique case (req_action_r)
              ACT_ADD: begin
                if (found || !full) begin
                  state_r <= INSERT;
                end else begin
                  out_valid_r           <= 1'b1;
                  out_word_r.out_weight <= 16'(req_weight_r);
                  out_word_r.status     <= ST_FULL;
                end
              end
              ACT_ERASE, ACT_QUERY: begin
                out_valid_r <= 1'b1;
                if (found) begin
                  out_word_r.out_weight <= 16'(hit_weight);
                  out_word_r.status     <= ST_OK;
                end else begin
                  out_word_r.status <= ST_NOT_FOUND;
                end
              end
              ACT_BEST_N, ACT_THRESH: begin
                if (first >= count_r) begin
                  out_valid_r       <= 1'b1;
                  out_word_r.out_id <= '0;
                  out_word_r.status <= ST_NONE;
                end else begin
                  ptr_r   <= first[XW-1:0];
                  state_r <= STREAM;
                end
              end
              default: begin
                out_valid_r       <= 1'b1;
                out_word_r.out_id <= '0;
                out_word_r.status <= ST_NONE;
              end
            endcase
          end
        end
        INSERT: begin
          if (step) begin
            out_valid_r            <= 1'b1;
            out_word_r.out_id      <= 16'(req_id_r);
            out_word_r.out_weight  <= 16'(req_weight_r);
            out_word_r.live_count  <= 6'(count_nxt);
            out_word_r.status      <= ST_OK;
            out_word_r.last_of_run <= 1'b1;
            state_r                <= IDLE;
          end
        end
        STREAM: begin
          if (step) begin
            out_valid_r            <= 1'b1;
            out_word_r.out_id      <= 16'(rd_id);
            out_word_r.out_weight  <= 16'(rd_weight);
            out_word_r.live_count  <= 6'(count_r);
            out_word_r.status      <= ST_OK;
            out_word_r.last_of_run <= stream_last;
            ptr_r                  <= ptr_r + XW'(1);
            if (stream_last) begin
              state_r <= IDLE;
            end
          end
        end
        default: begin
          state_r <= IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

/* rtl/swnl_checker.sv */
// Port-level checks for the sorted weighted neighbor list, bound to its top level.
// Watches the result channel only; depends on swnl_pkg.
module swnl_checker #(
  parameter int CAPACITY = 32
) (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input swnl_pkg::out_word_t out_word
);
  import swnl_pkg::*;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  // Any status other than OK ends the run of its input word.
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status != ST_OK |-> out_word.last_of_run)
    else $error("error or empty result not marked last");

  // An empty read carries zero id and weight.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_NONE |->
      out_word.out_id == '0 && out_word.out_weight == '0)
    else $error("empty result carries data");

  // A dropped add is only reported with the list at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.status == ST_FULL |-> out_word.live_count == 6'(CAPACITY))
    else $error("full status with room left");

  // The live count of a valid result never passes the capacity; checked for capacities below 64.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY >= 64) || (int'(out_word.live_count) <= CAPACITY))
    else $error("live count above capacity");

endmodule

bind sorted_weighted_neighbor_list swnl_checker #(
  .CAPACITY(CAPACITY)
) u_swnl_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_word (out_word)
);
